### hdl/fp8_block_scaled_dequant_assert.svh
// Assertion macros shared by the FP8 block-scaled dequantizer RTL.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef FP8_BLOCK_SCALED_DEQUANT_ASSERT_SVH
`define FP8_BLOCK_SCALED_DEQUANT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_RST(label, clk, rstn, prop, msg)
`endif
`endif

### hdl/fp8bsd_pkg.sv
// Package for the FP8 block-scaled dequantizer: constants and stage types.
// Depends on nothing.
package fp8bsd_pkg;
    localparam int unsigned Lanes = 4;
    localparam logic [31:0] QnanBits = 32'h7FC0_0000;
    localparam logic [31:0] InfBits = 32'h7F80_0000;
    localparam logic [6:0] NanMag = 7'h7f;
    localparam logic [7:0] ScaleInf = 8'hff;

    typedef struct packed {
        logic       sign;
        logic       is_zero;
        logic [3:0] sig;
        logic [4:0] p_exp;
    } dec_t;

    typedef struct packed {
        logic        sign;
        logic        is_zero;
        logic        is_inf;
        logic [2:0]  frac;
        logic [1:0]  msb;
        logic [9:0]  ex;
        logic [3:0]  sig;
    } exp_t;
endpackage

### hdl/fp8bsd_decode.sv
// Decodes one E4M3 byte into sign, zero flag and significand with exponent.
// Depends on fp8bsd_pkg.
module fp8bsd_decode (
    input  logic [7:0]          weight,
    output fp8bsd_pkg::dec_t    dec
);
    logic [6:0] mag;
    logic [3:0] e;
    always_comb begin
        mag = weight[6:0];
        e = mag[6:3];
        dec.sign = weight[7] && (mag != fp8bsd_pkg::NanMag);
        dec.is_zero = (mag == 7'd0) || (mag == fp8bsd_pkg::NanMag);
        if (e == 4'd0) begin
            dec.sig = {1'b0, mag[2:0]};
            dec.p_exp = 5'(-9);
        end else begin
            dec.sig = {1'b1, mag[2:0]};
            dec.p_exp = 5'({1'b0, e}) - 5'd10;
        end
    end
endmodule

### hdl/fp8bsd_expo.sv
// Finds the leading one and the unbiased product exponent for one lane.
// Depends on fp8bsd_pkg.
module fp8bsd_expo (
    input  fp8bsd_pkg::dec_t    dec,
    input  logic [7:0]          scale_exp,
    output fp8bsd_pkg::exp_t    ex_out
);
    logic [1:0] msb;
    logic [9:0] s;
    always_comb begin
        priority if (dec.sig[3]) msb = 2'd3;
        else if (dec.sig[2]) msb = 2'd2;
        else if (dec.sig[1]) msb = 2'd1;
        else msb = 2'd0;
        s = (scale_exp == 8'd0) ? 10'(-127) : 10'({2'b00, scale_exp}) - 10'd127;
        ex_out.sign = dec.sign;
        ex_out.is_zero = dec.is_zero;
        ex_out.is_inf = (scale_exp == fp8bsd_pkg::ScaleInf);
        ex_out.msb = msb;
        ex_out.sig = dec.sig;
        ex_out.frac = 3'(dec.sig << (2'd3 - msb));
        ex_out.ex = 10'({msb}) + {{5{dec.p_exp[4]}}, dec.p_exp} + s;
    end
endmodule

### hdl/fp8bsd_pack.sv
// Packs one lane into IEEE single bits, covering specials and subnormals.
// Depends on fp8bsd_pkg.
module fp8bsd_pack (
    input  fp8bsd_pkg::exp_t    ex_in,
    output logic [31:0]         value
);
    logic signed [9:0] ex;
    logic signed [9:0] sh;
    logic [22:0] sub;
    always_comb begin
        ex = ex_in.ex;
        sh = ex - 10'(ex_in.msb) + 10'sd149;
        if (sh < 0) sub = 23'd0;
        else sub = 23'({19'd0, ex_in.sig} << sh[4:0]);
        if (ex_in.is_zero) begin
            value = ex_in.is_inf ? fp8bsd_pkg::QnanBits : {ex_in.sign, 31'd0};
        end else if (ex_in.is_inf || ex > 10'sd127) begin
            value = {ex_in.sign, 31'd0} | fp8bsd_pkg::InfBits;
        end else if (ex >= -10'sd126) begin
            value = {ex_in.sign, 8'(ex + 10'sd127), ex_in.frac, 20'd0};
        end else begin
            value = {ex_in.sign, 8'd0, sub};
        end
    end
endmodule

### hdl/fp8_block_scaled_dequant.sv
// FP8 block-scaled dequantizer: four E4M3 bytes times an E8M0 scale, as IEEE singles.
// Registers follow decode, exponent and pack; one word per cycle while m_tready stays high.
// The pipeline is decode, exponent and pack stages; a stall holds only the full stages in place.
// Synchronous active-low reset clears the valid bits only; data registers are not reset.
// Depends on fp8bsd_pkg, fp8bsd_decode, fp8bsd_expo, fp8bsd_pack and the assertion header.
`include "fp8_block_scaled_dequant_assert.svh"
module fp8_block_scaled_dequant (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // weight_0, weight_1, weight_2, weight_3, scale_exp
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [127:0] m_tdata  // value_0, value_1, value_2, value_3
);
    localparam int unsigned L = fp8bsd_pkg::Lanes;

    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic en1, en2, en3;
    fp8bsd_pkg::dec_t dec_w [L];
    fp8bsd_pkg::dec_t d1_reg [L];
    logic [7:0] sc1_reg;
    fp8bsd_pkg::exp_t exp_w [L];
    fp8bsd_pkg::exp_t e2_reg [L];
    logic [127:0] pack_w;
    logic [127:0] out_reg;

    assign en3 = !v3_reg || m_tready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;
    assign v1_next = en1 ? s_tvalid : v1_reg;
    assign v2_next = en2 ? v1_reg : v2_reg;
    assign v3_next = en3 ? v2_reg : v3_reg;

    for (genvar i = 0; i < L; i++) begin : g_lane
        fp8bsd_decode u_dec (.weight(s_tdata[8*i +: 8]), .dec(dec_w[i]));
        fp8bsd_expo u_exp (.dec(d1_reg[i]), .scale_exp(sc1_reg), .ex_out(exp_w[i]));
        fp8bsd_pack u_pack (.ex_in(e2_reg[i]), .value(pack_w[32*i +: 32]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            d1_reg <= dec_w;
            sc1_reg <= s_tdata[39:32];
        end
        if (en2) e2_reg <= exp_w;
        if (en3) out_reg <= pack_w;
    end

    assign m_tvalid = v3_reg;
    assign m_tdata = out_reg;

    `ASSERT_CLK(a_hold_out, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "output word changed while stalled")
    `ASSERT_CLK(a_ready, aclk, aresetn, (!v3_reg || !v2_reg || !v1_reg) |-> s_tready, "input not ready with a free stage")
    `ASSERT_RST(a_reset, aclk, aresetn, !aresetn |=> !m_tvalid, "output valid after reset")
endmodule

### test/fp8_block_scaled_dequant_checker.sv
// Checker for the FP8 block-scaled dequantizer: watches both stream channels,
// predicts each output word from the accepted input word and compares lane by lane.
// Depends on nothing beyond the port widths of fp8_block_scaled_dequant.
module fp8_block_scaled_dequant_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [39:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] CanonNan = 32'h7FC0_0000;
    localparam logic [31:0] InfPattern = 32'h7F80_0000;

    logic [127:0] expected_words[$];

    function automatic logic [31:0] scaled_single(logic [7:0] w, logic [7:0] sc);
        logic       neg;
        logic [6:0] mag;
        logic [3:0] sig;
        int         p2, s2, top, ex, sh;
        neg = w[7];
        mag = w[6:0];
        if (mag == 7'h7f) begin
            neg = 1'b0;
            mag = '0;
        end
        if (mag == 0)
            return (sc == 8'hff) ? CanonNan : {neg, 31'd0};
        if (sc == 8'hff)
            return {neg, 31'd0} | InfPattern;
        if (mag[6:3] == 0) begin
            sig = {1'b0, mag[2:0]};
            p2 = -9;
        end else begin
            sig = {1'b1, mag[2:0]};
            p2 = int'(mag[6:3]) - 10;
        end
        s2 = (sc == 0) ? -127 : int'(sc) - 127;
        top = sig[3] ? 3 : sig[2] ? 2 : sig[1] ? 1 : 0;
        ex = top + p2 + s2;
        if (ex > 127)
            return {neg, 31'd0} | InfPattern;
        if (ex >= -126)
            return {neg, 8'(ex + 127), 23'((32'(sig) << (23 - top)) & 32'h7fffff)};
        sh = p2 + s2 + 149;
        if (sh < 0) sh = 0;
        if (sh > 31) sh = 31;
        return {neg, 31'd0} | ((32'(sig) << sh) & 32'h7fffff);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %08h expected %08h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        logic [127:0] want;
        if (aresetn && s_tvalid && s_tready) begin
            for (int i = 0; i < 4; i++)
                want[32*i +: 32] = scaled_single(s_tdata[8*i +: 8], s_tdata[39:32]);
            expected_words.push_back(want);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[31:0], 32'd0);
            end else begin
                want = expected_words.pop_front();
                for (int i = 0; i < 4; i++)
                    if (m_tdata[32*i +: 32] !== want[32*i +: 32])
                        report_mismatch($sformatf("value_%0d", i), m_tdata[32*i +: 32],
                                        want[32*i +: 32]);
            end
        end
        pending = expected_words.size();
    end
endmodule

### test/fp8_block_scaled_dequant_tb.sv
// Testbench top for fp8_block_scaled_dequant: drives directed and random words with
// random gaps and output stalls, and reports the verdict from the checker's count.
// Depends on fp8_block_scaled_dequant and fp8_block_scaled_dequant_checker.
module fp8_block_scaled_dequant_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    int           fail_count, pending;
    int           cycle_count = 0;
    bit           hold_off = 1'b0;

    fp8_block_scaled_dequant dut (.*);

    fp8_block_scaled_dequant_checker u_checker (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("fp8_block_scaled_dequant verification failed");
            $finish;
        end
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] random_weight();
        logic [7:0] w;
        w = 8'($urandom);
        case ($urandom_range(0, 7))
            0: w[6:0] = 7'h7f;
            1: w[6:0] = 7'h00;
            2: w[6:3] = 4'h0;
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] random_scale();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'(115 + $urandom_range(0, 24));
            3: return 8'($urandom_range(0, 12));
            4: return 8'($urandom_range(240, 254));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic [39:0] w);
        int g;
        g = gap_length();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tdata <= w;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2: m_tready <= 1'b0;
                default: m_tready <= 1'b1;
            endcase
        end
    end

    initial begin
        logic [7:0] directed_w[$];
        logic [7:0] directed_s[$];
        directed_w = '{8'h00, 8'h80, 8'h7f, 8'hff, 8'h01, 8'h81, 8'h07, 8'h08,
                       8'h7e, 8'hfe, 8'h38, 8'hb8, 8'h55, 8'haa};
        directed_s = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hfe, 8'hff, 8'h96, 8'h8a};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_s[k])
            for (int j = 0; j < directed_w.size(); j += 4)
                send_word({directed_s[k], directed_w[(j + 3) % directed_w.size()],
                           directed_w[(j + 2) % directed_w.size()],
                           directed_w[(j + 1) % directed_w.size()], directed_w[j]});
        fork
            begin
                repeat (200) @(posedge aclk);
                hold_off = 1'b1;
                repeat (60) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 1650; n++)
                send_word({random_scale(), random_weight(), random_weight(),
                           random_weight(), random_weight()});
        join
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("fp8_block_scaled_dequant verification clean");
        else
            $display("fp8_block_scaled_dequant verification failed");
        $finish;
    end
endmodule
